### rtl/core/wts_pkg.sv
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types, constants and helpers of the Williamson turn heading sequencer.
// ----------------------------------------------------------------------------
package wts_pkg;

  // Heading arithmetic, tenths of a degree
  localparam logic signed [13:0] FullCircleS = 14'sd3600;
  localparam logic signed [13:0] HalfCircleS = 14'sd1800;
  localparam logic [11:0]        FullCircle  = 12'd3600;
  localparam logic [11:0]        HalfCircle  = 12'd1800;
  localparam logic [7:0]         SettleMax   = 8'd255;

  // Opcodes
  localparam logic OpRun  = 1'b0;
  localparam logic OpIdle = 1'b1;

  // Phase codes
  localparam logic [1:0] PhaseInitial = 2'd0;
  localparam logic [1:0] PhaseLead    = 2'd1;
  localparam logic [1:0] PhaseCapture = 2'd2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 11;
  localparam logic [CfgIdxW-1:0] CfgHeadingTol = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgInitTurn   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxStep    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTurnDir    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCapRange   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSettleReq  = 3'd5;

  // Register reset values
  localparam logic [10:0] RstHeadingTol = 11'd10;
  localparam logic [10:0] RstInitTurn   = 11'd600;
  localparam logic [10:0] RstMaxStep    = 11'd900;
  localparam logic        RstTurnDir    = 1'b0;
  localparam logic [10:0] RstCapRange   = 11'd300;
  localparam logic [7:0]  RstSettleReq  = 8'd5;

  typedef struct packed {
    logic [10:0] tol_band;
    logic [10:0] swing_angle;
    logic [10:0] lead_limit;
    logic        swing_port;
    logic [10:0] capture_range;
    logic [7:0]  settle_required;
  } cfg_t;

  typedef struct packed {
    logic        opcode;
    logic        heading_valid;
    logic [11:0] meas_heading;
  } in_item_t;

  typedef struct packed {
    logic        course_valid;
    logic [11:0] desired_course;
    logic [1:0]  phase;
    logic        complete;
    logic        heading_missing;
  } out_item_t;

  typedef struct packed {
    logic        entry_latched;
    logic [11:0] entry_heading;
    logic [11:0] first_phase_heading;
    logic [11:0] reciprocal_heading;
    logic        first_phase_done;
    logic [7:0]  settle_counter;
  } maneuver_t;

  // Fold a value in [-3600, 7200) into [0, 3600)
  function automatic logic [11:0] wrap_heading(input logic signed [13:0] a);
    logic signed [13:0] r;
    r = a;
    if (a < 14'sd0) begin
      r = a + FullCircleS;
    end else if (a >= FullCircleS) begin
      r = a - FullCircleS;
    end
    return r[11:0];
  endfunction

endpackage

### rtl/core/wts_in_if.sv
// ----------------------------------------------------------------------------
// wts_in_if
// Helm tick channel: valid/ready handshake with opcode and measured heading.
// ----------------------------------------------------------------------------
interface wts_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic        heading_valid;
  logic [11:0] meas_heading;

  modport source (output valid, output opcode, output heading_valid,
                  output meas_heading, input ready);
  modport sink   (input valid, input opcode, input heading_valid,
                  input meas_heading, output ready);
endinterface

### rtl/core/wts_out_if.sv
// ----------------------------------------------------------------------------
// wts_out_if
// Course command channel: valid/ready handshake with the commanded course.
// ----------------------------------------------------------------------------
interface wts_out_if;
  logic        valid;
  logic        ready;
  logic        course_valid;
  logic [11:0] desired_course;
  logic [1:0]  phase;
  logic        complete;
  logic        heading_missing;

  modport source (output valid, output course_valid, output desired_course,
                  output phase, output complete, output heading_missing,
                  input ready);
  modport sink   (input valid, input course_valid, input desired_course,
                  input phase, input complete, input heading_missing,
                  output ready);
endinterface

### rtl/core/wts_cfg_regs.sv
// ----------------------------------------------------------------------------
// wts_cfg_regs
// Configuration register file: indexed writes, reset to default tuning.
// ----------------------------------------------------------------------------
module wts_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wts_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [wts_pkg::CfgDataW-1:0]  cfg_wdata,
  output wts_pkg::cfg_t                 cfg
);

  wts_pkg::cfg_t cfg_r;
  wts_pkg::cfg_t cfg_nxt;

  // Write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        wts_pkg::CfgHeadingTol: cfg_nxt.tol_band        = cfg_wdata;
        wts_pkg::CfgInitTurn:   cfg_nxt.swing_angle     = cfg_wdata;
        wts_pkg::CfgMaxStep:    cfg_nxt.lead_limit      = cfg_wdata;
        wts_pkg::CfgTurnDir:    cfg_nxt.swing_port      = cfg_wdata[0];
        wts_pkg::CfgCapRange:   cfg_nxt.capture_range   = cfg_wdata;
        wts_pkg::CfgSettleReq:  cfg_nxt.settle_required = cfg_wdata[7:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tol_band        <= wts_pkg::RstHeadingTol;
      cfg_r.swing_angle     <= wts_pkg::RstInitTurn;
      cfg_r.lead_limit      <= wts_pkg::RstMaxStep;
      cfg_r.swing_port      <= wts_pkg::RstTurnDir;
      cfg_r.capture_range   <= wts_pkg::RstCapRange;
      cfg_r.settle_required <= wts_pkg::RstSettleReq;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/wts_step.sv
// ----------------------------------------------------------------------------
// wts_step
// One helm tick: phase selection, lead-step course and settle tracking.
// ----------------------------------------------------------------------------
module wts_step (
  input  wts_pkg::in_item_t   item,
  input  wts_pkg::cfg_t       cfg,
  input  wts_pkg::maneuver_t  st,
  output wts_pkg::maneuver_t  st_nxt,
  output wts_pkg::out_item_t  res
);

  logic [11:0]        nav_w;
  logic               port;
  logic signed [13:0] nav_s;
  logic signed [13:0] init_s;
  logic signed [13:0] tol_s;
  logic [11:0]        fph_new;
  logic [11:0]        ent;
  logic [11:0]        fph;
  logic [11:0]        rec;
  logic               fpd_eff;
  logic [11:0]        d_ent;
  logic signed [13:0] delta;
  logic signed [13:0] sdelta;
  logic               turn_reached;
  logic [11:0]        d0;
  logic [11:0]        diff;
  logic [11:0]        lead;
  logic [11:0]        course1;
  logic [11:0]        err;
  logic               in_tol;
  logic               capture;
  logic [7:0]         cnt_inc;
  logic               settled;
  logic [1:0]         phase2;
  logic [11:0]        course2;

  // Heading folded into range, signed views of the angles
  always_comb begin
    nav_w  = (item.meas_heading >= wts_pkg::FullCircle) ?
             item.meas_heading - wts_pkg::FullCircle : item.meas_heading;
    port   = cfg.swing_port;
    nav_s  = $signed({2'b00, nav_w});
    init_s = $signed({3'b000, cfg.swing_angle});
    tol_s  = $signed({3'b000, cfg.tol_band});
  end

  // Entry values: latched ones, or taken from this tick on the first run
  always_comb begin
    fph_new = wts_pkg::wrap_heading(port ? nav_s - init_s : nav_s + init_s);
    ent     = st.entry_latched ? st.entry_heading : nav_w;
    fph     = st.entry_latched ? st.first_phase_heading : fph_new;
    rec     = st.entry_latched ? st.reciprocal_heading :
              wts_pkg::wrap_heading(nav_s + wts_pkg::HalfCircleS);
    fpd_eff = st.entry_latched & st.first_phase_done;
  end

  // Phase one: turned far enough from entry?
  always_comb begin
    d_ent        = wts_pkg::wrap_heading(nav_s - $signed({2'b00, ent}));
    delta        = (d_ent > wts_pkg::HalfCircle) ?
                   $signed({2'b00, d_ent}) - wts_pkg::FullCircleS :
                   $signed({2'b00, d_ent});
    sdelta       = port ? -delta : delta;
    turn_reached = (sdelta >= init_s - tol_s);
  end

  // Phase two: remaining angle, lead step and heading error
  always_comb begin
    d0      = wts_pkg::wrap_heading(nav_s - $signed({2'b00, rec}));
    if (!port) begin
      diff = d0;
    end else begin
      diff = (d0 == 12'd0) ? 12'd0 : wts_pkg::FullCircle - d0;
    end
    capture = (diff <= {1'b0, cfg.capture_range});
    lead    = (diff < {1'b0, cfg.lead_limit}) ? diff : {1'b0, cfg.lead_limit};
    course1 = wts_pkg::wrap_heading(port ? nav_s + $signed({2'b00, lead}) :
                                           nav_s - $signed({2'b00, lead}));
    phase2  = capture ? wts_pkg::PhaseCapture : wts_pkg::PhaseLead;
    course2 = capture ? rec : course1;
    err     = (d0 > wts_pkg::HalfCircle) ? wts_pkg::FullCircle - d0 : d0;
    in_tol  = (err <= {1'b0, cfg.tol_band});
    cnt_inc = (st.settle_counter == wts_pkg::SettleMax) ?
              wts_pkg::SettleMax : st.settle_counter + 8'd1;
    settled = (cnt_inc >= cfg.settle_required);
  end

  // Result and next maneuver state
  always_comb begin
    st_nxt = st;
    res    = '0;
    if (item.opcode == wts_pkg::OpIdle) begin
      st_nxt.entry_latched    = 1'b0;
      st_nxt.first_phase_done = 1'b0;
      st_nxt.settle_counter   = 8'd0;
    end else if (!item.heading_valid) begin
      res.heading_missing = 1'b1;
    end else begin
      st_nxt.entry_latched       = 1'b1;
      st_nxt.entry_heading       = ent;
      st_nxt.first_phase_heading = fph;
      st_nxt.reciprocal_heading  = rec;
      if (!fpd_eff && !turn_reached) begin
        st_nxt.first_phase_done = 1'b0;
        res.course_valid        = 1'b1;
        res.desired_course      = fph;
        res.phase               = wts_pkg::PhaseInitial;
      end else begin
        st_nxt.first_phase_done = 1'b1;
        res.phase               = phase2;
        if (in_tol && settled) begin
          st_nxt.entry_latched    = 1'b0;
          st_nxt.first_phase_done = 1'b0;
          st_nxt.settle_counter   = 8'd0;
          res.complete            = 1'b1;
          res.desired_course      = rec;
        end else begin
          st_nxt.settle_counter = in_tol ? cnt_inc : 8'd0;
          res.course_valid      = 1'b1;
          res.desired_course    = course2;
        end
      end
    end
  end

endmodule

### rtl/core/williamson_turn_heading_sequencer.sv
// Path: an accepted tick is held in the input register, then its result is
// registered in the result register, from which it transfers out.
// Throughput: one tick per cycle without stalls; the maneuver state updates in
// the same cycle the input register hands its tick to the result register.
// Reset (synchronous, active low): pipeline empty, maneuver cleared, registers
// back to their default tuning.
// ----------------------------------------------------------------------------
// williamson_turn_heading_sequencer
// Top level: input register, maneuver state, step logic and result register.
// ----------------------------------------------------------------------------
module williamson_turn_heading_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  wts_in_if.sink                        in_ch,
  wts_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [wts_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [wts_pkg::CfgDataW-1:0]  cfg_wdata
);

  wts_pkg::cfg_t      cfg;
  wts_pkg::in_item_t  s1_item_r;
  logic               s1_valid_r;
  wts_pkg::maneuver_t state_r;
  wts_pkg::maneuver_t state_nxt;
  wts_pkg::out_item_t res;
  wts_pkg::out_item_t out_r;
  logic               out_valid_r;
  logic               adv;
  logic               fire;
  logic               in_xfer;

  wts_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wts_step u_step (
    .item   (s1_item_r),
    .cfg    (cfg),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (res)
  );

  // Handshake: result register drains or is empty, input stage follows
  assign adv          = !out_valid_r || out_ch.ready;
  assign fire         = s1_valid_r && adv;
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.opcode        <= in_ch.opcode;
      s1_item_r.heading_valid <= in_ch.heading_valid;
      s1_item_r.meas_heading  <= in_ch.meas_heading;
    end
  end

  // Maneuver state advances once per processed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.course_valid    = out_r.course_valid;
  assign out_ch.desired_course  = out_r.desired_course;
  assign out_ch.phase           = out_r.phase;
  assign out_ch.complete        = out_r.complete;
  assign out_ch.heading_missing = out_r.heading_missing;

  // Checks
  a_done_implies_latched: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.first_phase_done |-> state_r.entry_latched)
    else $error("first phase done without a latched entry");

  a_complete_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.complete) |=> (!state_r.entry_latched && state_r.settle_counter == 8'd0))
    else $error("completion did not clear the maneuver");

  a_missing_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_item_r.opcode == wts_pkg::OpRun && !s1_item_r.heading_valid)
    |=> $stable(state_r))
    else $error("missing heading changed the maneuver state");

  a_course_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.course_valid) |-> (out_r.desired_course < wts_pkg::FullCircle))
    else $error("commanded course out of range");

  a_complete_no_course: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.complete) |=> (out_valid_r && !out_r.course_valid))
    else $error("completion result carries a course command");

endmodule
